// ===== design/max_heap_priority_queue_unit_macros.svh =====
// Assertion macros for the heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define MAX_HEAP_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define HPQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("heap queue assertion failed");
`define HPQ_NEVER(label, cond) \
	`HPQ_ASSERT(label, !(cond))
`else
`define HPQ_ASSERT(label, prop)
`define HPQ_NEVER(label, cond)
`endif

`endif

// ===== design/hpq_pkg.sv =====
package hpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int KEY_W    = 31;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CHILD_W  = CNT_W + 1;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [CHILD_W-1:0] child_t;
	typedef logic [1:0]         mode_t;
	typedef logic [1:0]         status_t;

	localparam mode_t MODE_INSERT = 2'd0;
	localparam mode_t MODE_REMOVE = 2'd1;
	localparam mode_t MODE_PEEK   = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_REM_RD = 8'b0000_0010,
		S_REM_LD = 8'b0000_0100,
		S_UP_CHK = 8'b0000_1000,
		S_UP_CMP = 8'b0001_0000,
		S_DN_CHK = 8'b0010_0000,
		S_DN_CMP = 8'b0100_0000,
		S_FIN    = 8'b1000_0000
	} hpq_state_t;

	// 1-based heap position to memory address
	function automatic addr_t pos_addr(input cnt_t pos);
		cnt_t tmp;
		tmp = pos - 1'b1;
		return tmp[ADDR_W-1:0];
	endfunction

endpackage

// ===== design/max_heap_priority_queue_unit.sv =====
// Binary max-heap priority queue of up to 1024 unsigned 31-bit keys, kept in
// one synchronous memory (two read ports, one write port, registered reads).
// Each request is one operation: insert, remove maximum or peek, and each
// yields exactly one result. A peek or a refused request goes straight to the
// finish state; an insert rises from the new last position one level per
// check and compare step until its parent is not smaller or it reaches the
// root; a remove reads the last key, loads it at the root and sinks it one
// level per check and compare step until no child is larger or it ends on a
// leaf. Every sift level is a memory read followed by a compare and
// write-back. The next request can be taken once the result is in the output
// register, even while that result still waits on a stalled output; a result
// that finds the output register still occupied holds until it drains.
// No clearing pass is needed after reset.
`include "max_heap_priority_queue_unit_macros.svh"

module max_heap_priority_queue_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  hpq_pkg::mode_t    mode,
	input  hpq_pkg::key_t     value,
	output logic              out_valid,
	input  logic              out_stall,
	output hpq_pkg::key_t     result_value,
	output hpq_pkg::cnt_t     entry_count,
	output hpq_pkg::status_t  status
);
	import hpq_pkg::*;

	hpq_state_t state_q, state_d;
	cnt_t       count_q;
	cnt_t       pos_q;
	key_t       val_q;
	key_t       res_q;
	key_t       root_q;
	status_t    status_q;
	logic       take_top_q;

	logic       out_valid_q;
	key_t       result_value_q;
	cnt_t       entry_count_q;
	status_t    status_out_q;

	key_t       mem [CAPACITY];
	key_t       rd0_q, rd1_q;
	addr_t      ra0, ra1, wa;
	key_t       wd;
	logic       we;

	child_t     lc, rc;
	cnt_t       parent;
	logic       no_child, rc_ok, big_right;
	key_t       big_key;
	logic       in_acc, out_free;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign lc        = {pos_q, 1'b0};
	assign rc        = {pos_q, 1'b1};
	assign parent    = pos_q >> 1;
	assign no_child  = lc > {1'b0, count_q};
	assign rc_ok     = rc <= {1'b0, count_q};
	assign big_right = rc_ok && (rd0_q < rd1_q);
	assign big_key   = big_right ? rd1_q : rd0_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd0_q <= mem[ra0];
		rd1_q <= mem[ra1];
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		wa      = pos_addr(pos_q);
		wd      = val_q;
		ra0     = '0;
		ra1     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (mode)
						MODE_INSERT: state_d = (count_q >= CNT_W'(CAPACITY)) ? S_FIN : S_UP_CHK;
						MODE_REMOVE: state_d = (count_q == '0) ? S_FIN : S_REM_RD;
						default:     state_d = S_FIN;
					endcase
				end
			end
			S_REM_RD: begin
				ra0     = pos_addr(count_q);
				state_d = S_REM_LD;
			end
			S_REM_LD: state_d = S_DN_CHK;
			S_UP_CHK: begin
				if (pos_q == CNT_W'(1)) begin
					we      = 1'b1;
					state_d = S_FIN;
				end else begin
					ra0     = pos_addr(parent);
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (rd0_q < val_q) begin
					// pull the parent down, keep rising
					wd      = rd0_q;
					state_d = S_UP_CHK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DN_CHK: begin
				if (no_child) begin
					we      = 1'b1;
					state_d = S_FIN;
				end else begin
					ra0     = ADDR_W'(lc - 1'b1);
					ra1     = ADDR_W'(lc);
					state_d = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (big_key > val_q) begin
					// lift the larger child, keep sinking
					wd      = big_key;
					state_d = S_DN_CHK;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && in_acc && mode == MODE_INSERT
					&& count_q < CNT_W'(CAPACITY)) begin
				count_q <= count_q + 1'b1;
			end
			if (state_q == S_REM_LD) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we && wa == '0) begin
			root_q <= wd;
		end
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					pos_q      <= count_q + 1'b1;
					val_q      <= value;
					res_q      <= (count_q == '0) ? '0 : root_q;
					take_top_q <= (mode != MODE_REMOVE);
					status_q   <= ST_OK;
					if (mode == MODE_INSERT && count_q >= CNT_W'(CAPACITY)) begin
						status_q <= ST_FULL;
					end
					if (mode == MODE_REMOVE && count_q == '0) begin
						status_q <= ST_EMPTY;
					end
				end
			end
			S_REM_LD: begin
				val_q <= rd0_q;
				pos_q <= CNT_W'(1);
			end
			S_UP_CMP: begin
				if (rd0_q < val_q) begin
					pos_q <= parent;
				end
			end
			S_DN_CMP: begin
				if (big_key > val_q) begin
					pos_q <= big_right ? rc[CNT_W-1:0] : lc[CNT_W-1:0];
				end
			end
			S_FIN: begin
				if (out_free) begin
					result_value_q <= take_top_q ? ((count_q == '0) ? '0 : root_q) : res_q;
					entry_count_q  <= count_q;
					status_out_q   <= status_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign entry_count  = entry_count_q;
	assign status       = status_out_q;

	`HPQ_NEVER(a_count_in_range, count_q > CNT_W'(CAPACITY))
	`HPQ_ASSERT(a_full_means_full, (out_valid && status == ST_FULL) |-> (entry_count == CNT_W'(CAPACITY)))
	`HPQ_ASSERT(a_empty_reports_zero, (out_valid && status == ST_EMPTY) |-> (result_value == '0 && entry_count == '0))
	`HPQ_ASSERT(a_sift_down_in_heap, (state_q == S_DN_CMP) |-> (lc <= {1'b0, count_q}))

endmodule

// ===== tb/tb_max_heap_priority_queue_unit.sv =====
`timescale 1ns / 100ps

module tb_max_heap_priority_queue_unit;
	import hpq_pkg::*;

	// mode 3 has no meaning of its own and must act as a peek
	localparam mode_t MODE_SPARE = 2'd3;
	localparam int    STUCK_LIMIT = 2000;
	localparam int    DRAIN_CYCLES = 40;

	typedef struct {
		key_t    top;
		cnt_t    count;
		status_t st;
	} reply_t;

	typedef struct packed {
		mode_t   op;
		key_t    key;
		logic    fixed;
		key_t    top;
		cnt_t    count;
		status_t st;
	} dir_row_t;

	// fixed rows carry a reply that follows directly from the row; the rest go
	// through the heap model
	localparam dir_row_t DIRECTED [22] = '{
		'{MODE_PEEK,   31'h0,        1'b1, 31'h0,        11'd0, ST_OK},
		'{MODE_REMOVE, 31'h7FFFFFFF, 1'b1, 31'h0,        11'd0, ST_EMPTY},
		'{MODE_SPARE,  31'h7FFFFFFF, 1'b1, 31'h0,        11'd0, ST_OK},
		'{MODE_INSERT, 31'h0,        1'b1, 31'h0,        11'd1, ST_OK},
		'{MODE_INSERT, 31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF, 11'd2, ST_OK},
		'{MODE_INSERT, 31'h7FFFFFFF, 1'b1, 31'h7FFFFFFF, 11'd3, ST_OK},
		'{MODE_INSERT, 31'h2AAAAAAA, 1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_INSERT, 31'h55555555, 1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_INSERT, 31'h1,        1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_INSERT, 31'h55555555, 1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_PEEK,   31'h0,        1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_SPARE,  31'h2AAAAAAA, 1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b1, 31'h7FFFFFFF, 11'd6, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b1, 31'h7FFFFFFF, 11'd5, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_REMOVE, 31'h7FFFFFFF, 1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b0, 31'h0,        11'd0, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b1, 31'h0,        11'd0, ST_EMPTY},
		'{MODE_INSERT, 31'h40000000, 1'b1, 31'h40000000, 11'd1, ST_OK},
		'{MODE_REMOVE, 31'h0,        1'b1, 31'h40000000, 11'd0, ST_OK}
	};

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_stall;
	mode_t   mode;
	key_t    value;
	logic    out_valid;
	logic    out_stall;
	key_t    result_value;
	cnt_t    entry_count;
	status_t status;

	key_t   heap_keys [1:CAPACITY];
	int     heap_size;
	reply_t heap_replies [$];

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int n_requests;
	int n_replies;
	int peak_size;
	int n_refused_full;
	int n_refused_empty;
	int stuck_cycles;

	max_heap_priority_queue_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.entry_count  (entry_count),
		.status       (status)
	);

	always #5 clk = ~clk;

	// apply one operation to the heap copy and return the reply it yields
	function automatic reply_t apply_heap_op(mode_t op, key_t key);
		reply_t r;
		int     pos;
		int     child;
		key_t   tmp;
		r.top = '0;
		r.st = ST_OK;
		if (op == MODE_INSERT) begin
			if (heap_size >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				heap_size++;
				heap_keys[heap_size] = key;
				pos = heap_size;
				while (pos > 1 && heap_keys[pos / 2] < heap_keys[pos]) begin
					tmp = heap_keys[pos / 2];
					heap_keys[pos / 2] = heap_keys[pos];
					heap_keys[pos] = tmp;
					pos = pos / 2;
				end
			end
			r.top = (heap_size != 0) ? heap_keys[1] : '0;
		end else if (op == MODE_REMOVE) begin
			if (heap_size == 0) begin
				r.st = ST_EMPTY;
			end else begin
				r.top = heap_keys[1];
				heap_keys[1] = heap_keys[heap_size];
				heap_size--;
				pos = 1;
				while (2 * pos <= heap_size) begin
					child = 2 * pos;
					if (child + 1 <= heap_size && heap_keys[child] < heap_keys[child + 1])
						child++;
					if (heap_keys[child] <= heap_keys[pos])
						break;
					tmp = heap_keys[child];
					heap_keys[child] = heap_keys[pos];
					heap_keys[pos] = tmp;
					pos = child;
				end
			end
		end else begin
			r.top = (heap_size != 0) ? heap_keys[1] : '0;
		end
		r.count = cnt_t'(heap_size);
		return r;
	endfunction

	function automatic key_t random_key();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {KEY_W{1'b1}};
			2, 3: return key_t'($urandom_range(0, 15));
			default: return key_t'($urandom);
		endcase
	endfunction

	function automatic mode_t pick_mode(int ins_pct, int rem_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < ins_pct)
			return MODE_INSERT;
		if (r < ins_pct + rem_pct)
			return MODE_REMOVE;
		return ($urandom_range(0, 3) != 0) ? MODE_PEEK : MODE_SPARE;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at reply %0d, %s: got %h, want %h", n_replies, what, got, want);
		mismatches++;
	endtask

	// hold the request until taken, then log the reply it must produce
	task automatic send_request(input mode_t op, input key_t key, input logic fixed,
			input reply_t fixed_reply);
		reply_t r;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		value <= key;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		r = apply_heap_op(op, key);
		if (r.st == ST_FULL)
			n_refused_full++;
		if (r.st == ST_EMPTY)
			n_refused_empty++;
		if (heap_size > peak_size)
			peak_size = heap_size;
		n_requests++;
		heap_replies.push_back(fixed ? fixed_reply : r);
	endtask

	task automatic send_random(input mode_t op);
		reply_t unused;
		unused.top = '0;
		unused.count = '0;
		unused.st = ST_OK;
		send_request(op, random_key(), 1'b0, unused);
	endtask

	task automatic run_mix(input int items, input int ins_pct, input int rem_pct);
		repeat (items)
			send_random(pick_mode(ins_pct, rem_pct));
	endtask

	// reply side: check at the handshake, then pick next stall
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			n_replies++;
			if (heap_replies.size() == 0) begin
				flag_mismatch("reply with none awaited", 32'(result_value), '0);
			end else begin
				want = heap_replies.pop_front();
				if (result_value !== want.top)
					flag_mismatch("result_value", 32'(result_value), 32'(want.top));
				if (entry_count !== want.count)
					flag_mismatch("entry_count", 32'(entry_count), 32'(want.count));
				if (status !== want.st)
					flag_mismatch("status", 32'(status), 32'(want.st));
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// end the run when neither a request nor a reply moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("timeout: nothing moved for %0d cycles", STUCK_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		reply_t row_reply;
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_PEEK;
		value = '0;
		out_stall = 1'b0;
		heap_size = 0;
		mismatches = 0;
		n_requests = 0;
		n_replies = 0;
		peak_size = 0;
		n_refused_full = 0;
		n_refused_empty = 0;
		stuck_cycles = 0;
		send_idle_pct = 29;
		recv_stall_pct = 63;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row_reply.top = DIRECTED[i].top;
			row_reply.count = DIRECTED[i].count;
			row_reply.st = DIRECTED[i].st;
			send_request(DIRECTED[i].op, DIRECTED[i].key, DIRECTED[i].fixed, row_reply);
		end

		run_mix(100, 85, 10);
		send_idle_pct = 63;
		recv_stall_pct = 29;
		run_mix(100, 85, 10);

		// fill to capacity, bounce off the top, then sink keys through a full tree
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (heap_size < CAPACITY)
			send_random(MODE_INSERT);
		repeat (8)
			send_random(MODE_INSERT);
		send_random(MODE_PEEK);
		run_mix(40, 15, 80);

		in_valid <= 1'b0;
		while (heap_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d replies, heap peaked at %0d of %0d keys",
			n_requests, n_replies, peak_size, CAPACITY);
		$display("refused: %0d inserts on a full heap, %0d removes on an empty one",
			n_refused_full, n_refused_empty);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
